// File: rtl/pcmf_pkg.sv
// Package for the PCM to float32 converter: payload structs, format codes
// and shared constants. No dependencies.
package pcmf_pkg;

  typedef enum logic [2:0] {
    FMT_INT8  = 3'd0,
    FMT_INT16 = 3'd1,
    FMT_INT24 = 3'd2,
    FMT_INT32 = 3'd3,
    FMT_F32   = 3'd4,
    FMT_F64   = 3'd5,
    FMT_BAD6  = 3'd6,
    FMT_BAD7  = 3'd7
  } fmt_e;

  localparam logic [2:0] FmtReset = 3'd1;
  localparam logic [31:0] F32Inf = 32'h7f800000;

  typedef struct packed {
    logic [63:0] raw_sample;
    logic        end_of_buffer;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] float_bits;
    logic        end_of_buffer_out;
    logic        format_error;
  } out_beat_t;

endpackage

// File: rtl/pcmf_int_conv.sv
// Converts a signed integer sample of 8, 16, 24 or 32 bits to float32 bits,
// scaled by 2^-(width-1). Depends on pcmf_pkg.
module pcmf_int_conv (
  input  logic [31:0] val_i,
  input  logic [1:0]  wsel_i,
  output logic [31:0] bits_o
);
  import pcmf_pkg::*;

  logic [31:0] v;
  logic        sgn;
  logic [31:0] mag;
  logic [4:0]  p;
  logic [7:0]  bexp;
  logic [31:0] norm;
  logic [23:0] q;
  logic        rb, st;
  logic [24:0] qr;
  logic [7:0]  scale;

  always_comb begin
    unique case (wsel_i)
      2'd0: begin v = {{24{val_i[7]}}, val_i[7:0]};   scale = 8'd7;  end
      2'd1: begin v = {{16{val_i[15]}}, val_i[15:0]}; scale = 8'd15; end
      2'd2: begin v = {{8{val_i[23]}}, val_i[23:0]};  scale = 8'd23; end
      default: begin v = val_i; scale = 8'd31; end
    endcase
    sgn = v[31];
    mag = sgn ? (32'd0 - v) : v;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) p = 5'(i);
    end
    norm = mag << (5'd31 - p);
    q  = norm[31:8];
    rb = norm[7];
    st = |norm[6:0];
    qr = {1'b0, q} + 25'(rb & (st | q[0]));
    bexp = 8'd127 + {3'd0, p} - scale;
    if (mag == 32'd0) begin
      bits_o = 32'd0;
    end else if (qr[24]) begin
      bits_o = {sgn, bexp + 8'd1, 23'd0};
    end else begin
      bits_o = {sgn, bexp, qr[22:0]};
    end
  end
endmodule

// File: rtl/pcmf_f64_conv.sv
// Rounds float64 bits to float32 bits, nearest even, with subnormals,
// overflow to infinity and quiet NaN. Depends on pcmf_pkg.
module pcmf_f64_conv (
  input  logic [63:0] d_i,
  output logic [31:0] bits_o
);
  import pcmf_pkg::*;

  logic        sgn;
  logic [10:0] ex;
  logic [51:0] frac;
  logic [12:0] e32;
  logic [12:0] sh;
  logic [53:0] m;
  logic [53:0] shm;
  logic        sticky_extra;
  logic [23:0] q;
  logic        rb, st;
  logic [31:0] mag;

  always_comb begin
    sgn  = d_i[63];
    ex   = d_i[62:52];
    frac = d_i[51:0];
    // Biased float32 exponent of a normal result.
    e32 = {2'd0, ex} - 13'd896;
    m   = {1'b0, 1'b1, frac};
    sh  = 13'd0;
    shm = m;
    sticky_extra = 1'b0;
    if ($signed(e32) >= 13'sd1) begin
      shm = m;
    end else begin
      sh = 13'd1 - e32;
      if (sh > 13'd40) begin
        shm = 54'd0;
        sticky_extra = |m;
      end else begin
        shm = m >> sh[5:0];
        sticky_extra = |(m & ((54'd1 << sh[5:0]) - 54'd1));
      end
    end
    // shm holds hidden bit at [52], 23 fraction bits at [51:29].
    q  = shm[52:29];
    rb = shm[28];
    st = (|shm[27:0]) | sticky_extra;
    if ($signed(e32) >= 13'sd1) begin
      mag = {1'b0, e32[7:0], q[22:0]} + 32'(rb & (st | q[0]));
      if ($signed(e32) >= 13'sd255 || mag >= F32Inf) mag = F32Inf;
    end else begin
      mag = {8'd0, q} + 32'(rb & (st | q[0]));
    end
    if (ex == 11'h7ff) begin
      if (frac == 52'd0) bits_o = {sgn, F32Inf[30:0]};
      else bits_o = {sgn, 31'h7fc00000 | {9'd0, frac[50:29]}};
    end else if (ex == 11'd0) begin
      bits_o = {sgn, 31'd0};
    end else begin
      bits_o = {sgn, mag[30:0]};
    end
  end
endmodule

// File: rtl/pcm_sample_to_float32.sv
// PCM sample to float32 converter: input register, conversion logic, result
// register. Depends on pcmf_pkg, pcmf_int_conv and pcmf_f64_conv.
//
// Usage: drive in_i and raise start_i; the beat is taken at any rising edge
// with start_i high and busy_o low. busy_o is always low, so a sample may be
// taken in every cycle. Each accepted beat gives exactly one result beat on
// out_o, marked by done_o for exactly one cycle, after the beat has gone
// through the input register and the result register. Throughput is one
// sample per cycle.
// The format register is written through cfg_valid_i/cfg_ready_o with
// cfg_data_i; cfg_ready_o is always high. Write it only while no beat is in
// flight. Reset sets the format to int16 and clears both valid flags, so no
// result is shown after reset until a beat is accepted.
// The receiver cannot stall: a result is shown for one cycle only and must be
// taken then.
module pcm_sample_to_float32 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  pcmf_pkg::in_beat_t  in_i,
  output logic                done_o,
  output pcmf_pkg::out_beat_t out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_data_i
);
  import pcmf_pkg::*;

  logic [2:0] fmt_reg_q;
  logic       in_vld_q;
  in_beat_t   in_q;
  logic       out_vld_q;
  out_beat_t  out_q, out_d;
  logic [31:0] int_bits, f64_bits;
  logic [1:0]  wsel;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_reg_q <= FmtReset;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) fmt_reg_q <= cfg_data_i;
      in_vld_q  <= start_i;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) in_q <= in_i;
    out_q <= out_d;
  end

  assign wsel = fmt_reg_q[1:0];

  pcmf_int_conv u_int (
    .val_i  (in_q.raw_sample[31:0]),
    .wsel_i (wsel),
    .bits_o (int_bits)
  );

  pcmf_f64_conv u_f64 (
    .d_i    (in_q.raw_sample),
    .bits_o (f64_bits)
  );

  always_comb begin
    out_d.end_of_buffer_out = in_q.end_of_buffer;
    out_d.format_error      = 1'b0;
    unique case (fmt_e'(fmt_reg_q))
      FMT_INT8, FMT_INT16, FMT_INT24, FMT_INT32: out_d.float_bits = int_bits;
      FMT_F32: out_d.float_bits = in_q.raw_sample[31:0];
      FMT_F64: out_d.float_bits = f64_bits;
      default: begin
        out_d.float_bits   = 32'd0;
        out_d.format_error = 1'b1;
      end
    endcase
  end

  assign done_o = out_vld_q;
  assign out_o  = out_q;

`ifndef SYNTHESIS
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> ##1 done_o) else $error("result beat missing");
  a_nospur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 2)) else $error("spurious result beat");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.format_error) |-> out_o.float_bits == 32'd0)
    else $error("error beat carries data");
`endif
endmodule
